// File: src/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the peer choke scheduler.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // input transaction actions
    localparam logic [1:0] ACT_UPDATE   = 2'd0;
    localparam logic [1:0] ACT_ROUND    = 2'd1;
    localparam logic [1:0] ACT_NEXT_OPT = 2'd2;

    // configuration register indexes
    localparam logic CFG_PEER_COUNT    = 1'b0;
    localparam logic CFG_UNCHOKE_SLOTS = 1'b1;

    // configuration reset values
    localparam logic [5:0] PEER_COUNT_RST    = 6'd1;
    localparam logic [5:0] UNCHOKE_SLOTS_RST = 6'd4;

    localparam int RATE_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPT,
        ST_SCAN,
        ST_PICK,
        ST_SUMMARY
    } state_t;

endpackage

// File: src/pcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/peer_choke_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_choke_scheduler
// Tit-for-tat choke scheduler over a table of peers. Rates live in a RAM;
// a round ranks peers by repeated max-selection scans through one comparator.
// ----------------------------------------------------------------------------
// Update transaction: busy stays low, ready again next cycle.
// Round transaction: n = peers in use, r = n or n-1 ranked peers (n-1 with a
// live optimistic peer). Each rank position needs a scan of the n peers in use
// through the single read port of the rate RAM and one comparator.
// Results come out as they are found, summary last; no stalling. Busy holds off new commands.
// Reset: all peers choked, none interested, no optimistic peer, rates undefined.
// ----------------------------------------------------------------------------
module peer_choke_scheduler #(
    parameter int MAX_PEERS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [4:0] peer_index,
    input  logic [31:0] rate_down,
    input  logic [31:0] rate_up,
    input  logic       wants,
    input  logic       fresh,
    input  logic       seeding,
    input  logic       explicit_pick,
    // configuration
    input  logic       cfg_wr,
    input  logic       cfg_addr,
    input  logic [5:0] cfg_data,
    // results
    output logic       result_valid,
    output logic       change_valid,
    output logic [4:0] peer_index_res,
    output logic       unchoke,
    output logic [5:0] slots_used,
    output logic [4:0] optimistic_index,
    output logic       optimistic_valid,
    output logic       last
);

    localparam int DEPTH = (MAX_PEERS < 32) ? MAX_PEERS : 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RW    = pcs_pkg::RATE_W;

    pcs_pkg::state_t state_reg, state_next;

    logic [5:0]       peer_count_reg, peer_count_next;
    logic [5:0]       slots_cfg_reg, slots_cfg_next;
    logic [4:0]       opt_peer_reg, opt_peer_next;
    logic             opt_set_reg, opt_set_next;
    logic             seeding_reg, seeding_next;
    logic [DEPTH-1:0] choked_reg, choked_next;
    logic [DEPTH-1:0] interested_reg, interested_next;
    logic [DEPTH-1:0] ranked_reg, ranked_next;
    logic [CW-1:0]    rank_left_reg, rank_left_next;
    logic [5:0]       slots_reg, slots_next;
    logic [CW-1:0]    scan_addr_reg, scan_addr_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [RW-1:0]    best_rate_reg, best_rate_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    logic             best_found_reg, best_found_next;

    logic       res_valid_reg, res_valid_next;
    logic       res_change_reg, res_change_next;
    logic [4:0] res_peer_reg, res_peer_next;
    logic       res_unchoke_reg, res_unchoke_next;
    logic [5:0] res_slots_reg, res_slots_next;
    logic [4:0] res_opt_reg, res_opt_next;
    logic       res_opt_vld_reg, res_opt_vld_next;
    logic       res_last_reg, res_last_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [2*RW-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [2*RW-1:0] ram_rdata;

    logic [5:0]    n_eff;
    logic          opt_live;
    logic [AW-1:0] opt_addr;
    logic          accept;
    logic          issuing;
    logic [RW-1:0] rd_rate;
    logic [5:0]    opt_inc;

    pcs_ram #(
        .WIDTH (2 * RW),
        .DEPTH (DEPTH)
    ) u_rate_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (peer_count_reg == 6'd0)
        begin
            n_eff = 6'd1;
        end
        else if (peer_count_reg > 6'(DEPTH))
        begin
            n_eff = 6'(DEPTH);
        end
        else
        begin
            n_eff = peer_count_reg;
        end
    end

    assign busy      = (state_reg != pcs_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign opt_live  = opt_set_reg && ({1'b0, opt_peer_reg} < n_eff);
    assign opt_addr  = opt_peer_reg[AW-1:0];
    assign opt_inc   = {1'b0, opt_peer_reg} + 6'd1;
    assign issuing   = (6'(scan_addr_reg) < n_eff);
    assign rd_rate   = seeding_reg ? ram_rdata[2*RW-1:RW] : ram_rdata[RW-1:0];

    assign ram_we    = accept && (action == pcs_pkg::ACT_UPDATE)
                       && ({1'b0, peer_index} < 6'(DEPTH));
    assign ram_waddr = peer_index[AW-1:0];
    assign ram_wdata = {rate_up, rate_down};
    assign ram_raddr = scan_addr_reg[AW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        peer_count_next  = peer_count_reg;
        slots_cfg_next   = slots_cfg_reg;
        opt_peer_next    = opt_peer_reg;
        opt_set_next     = opt_set_reg;
        seeding_next     = seeding_reg;
        choked_next      = choked_reg;
        interested_next  = interested_reg;
        ranked_next      = ranked_reg;
        rank_left_next   = rank_left_reg;
        slots_next       = slots_reg;
        scan_addr_next   = scan_addr_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        best_rate_next   = best_rate_reg;
        best_idx_next    = best_idx_reg;
        best_found_next  = best_found_reg;
        res_valid_next   = 1'b0;
        res_change_next  = res_change_reg;
        res_peer_next    = res_peer_reg;
        res_unchoke_next = res_unchoke_reg;
        res_slots_next   = res_slots_reg;
        res_opt_next     = res_opt_reg;
        res_opt_vld_next = res_opt_vld_reg;
        res_last_next    = res_last_reg;

        if (cfg_wr)
        begin
            case (cfg_addr)
                pcs_pkg::CFG_PEER_COUNT:    peer_count_next = cfg_data;
                pcs_pkg::CFG_UNCHOKE_SLOTS: slots_cfg_next  = cfg_data;
                default:                    ;
            endcase
        end

        case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    seeding_next = seeding;
                    case (action)
                        pcs_pkg::ACT_UPDATE:
                        begin
                            if ({1'b0, peer_index} < 6'(DEPTH))
                            begin
                                interested_next[peer_index[AW-1:0]] = wants;
                                if (fresh)
                                begin
                                    choked_next[peer_index[AW-1:0]] = 1'b1;
                                end
                            end
                        end
                        pcs_pkg::ACT_ROUND:
                        begin
                            state_next = pcs_pkg::ST_OPT;
                        end
                        pcs_pkg::ACT_NEXT_OPT:
                        begin
                            if (explicit_pick)
                            begin
                                opt_peer_next = peer_index;
                            end
                            else if (!opt_set_reg)
                            begin
                                opt_peer_next = 5'd0;
                            end
                            else if (opt_inc >= n_eff)
                            begin
                                opt_peer_next = 5'd0;
                            end
                            else
                            begin
                                opt_peer_next = opt_inc[4:0];
                            end
                            opt_set_next = 1'b1;
                            state_next   = pcs_pkg::ST_OPT;
                        end
                        default: ;
                    endcase
                end
            end

            pcs_pkg::ST_OPT:
            begin
                ranked_next    = '0;
                slots_next     = 6'd0;
                rank_left_next = CW'(n_eff - {5'd0, opt_live});
                scan_addr_next = '0;
                best_found_next = 1'b0;
                if (opt_live)
                begin
                    ranked_next[opt_addr] = 1'b1;
                    slots_next = {5'd0, interested_reg[opt_addr]};
                    if (choked_reg[opt_addr])
                    begin
                        choked_next[opt_addr] = 1'b0;
                        res_valid_next   = 1'b1;
                        res_change_next  = 1'b1;
                        res_peer_next    = opt_peer_reg;
                        res_unchoke_next = 1'b1;
                        res_slots_next   = 6'd0;
                        res_opt_next     = 5'd0;
                        res_opt_vld_next = 1'b0;
                        res_last_next    = 1'b0;
                    end
                end
                if (n_eff == {5'd0, opt_live})
                begin
                    state_next = pcs_pkg::ST_SUMMARY;
                end
                else
                begin
                    state_next = pcs_pkg::ST_SCAN;
                end
            end

            pcs_pkg::ST_SCAN:
            begin
                // issue one read per cycle, compare the data from the cycle before
                if (issuing)
                begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
                // strict greater keeps the lower index on equal rates
                if (cmp_vld_reg && !ranked_reg[cmp_idx_reg]
                    && (!best_found_reg || (rd_rate > best_rate_reg)))
                begin
                    best_found_next = 1'b1;
                    best_rate_next  = rd_rate;
                    best_idx_next   = cmp_idx_reg;
                end
                if (!issuing && !cmp_vld_reg)
                begin
                    state_next = pcs_pkg::ST_PICK;
                end
            end

            pcs_pkg::ST_PICK:
            begin
                ranked_next[best_idx_reg] = 1'b1;
                rank_left_next = rank_left_reg - CW'(1);
                res_peer_next    = 5'(best_idx_reg);
                res_change_next  = 1'b1;
                res_slots_next   = 6'd0;
                res_opt_next     = 5'd0;
                res_opt_vld_next = 1'b0;
                res_last_next    = 1'b0;
                if (slots_reg < slots_cfg_reg)
                begin
                    if (interested_reg[best_idx_reg])
                    begin
                        slots_next = slots_reg + 6'd1;
                    end
                    if (choked_reg[best_idx_reg])
                    begin
                        choked_next[best_idx_reg] = 1'b0;
                        res_valid_next   = 1'b1;
                        res_unchoke_next = 1'b1;
                    end
                end
                else if (!choked_reg[best_idx_reg])
                begin
                    choked_next[best_idx_reg] = 1'b1;
                    res_valid_next   = 1'b1;
                    res_unchoke_next = 1'b0;
                end
                scan_addr_next  = '0;
                best_found_next = 1'b0;
                if (rank_left_reg == CW'(1))
                begin
                    state_next = pcs_pkg::ST_SUMMARY;
                end
                else
                begin
                    state_next = pcs_pkg::ST_SCAN;
                end
            end

            pcs_pkg::ST_SUMMARY:
            begin
                res_valid_next   = 1'b1;
                res_change_next  = 1'b0;
                res_peer_next    = 5'd0;
                res_unchoke_next = 1'b0;
                res_slots_next   = slots_reg;
                res_opt_next     = opt_peer_reg;
                res_opt_vld_next = opt_set_reg;
                res_last_next    = 1'b1;
                state_next       = pcs_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcs_pkg::ST_IDLE;
            peer_count_reg <= pcs_pkg::PEER_COUNT_RST;
            slots_cfg_reg  <= pcs_pkg::UNCHOKE_SLOTS_RST;
            opt_peer_reg   <= 5'd0;
            opt_set_reg    <= 1'b0;
            choked_reg     <= '1;
            interested_reg <= '0;
            cmp_vld_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            peer_count_reg <= peer_count_next;
            slots_cfg_reg  <= slots_cfg_next;
            opt_peer_reg   <= opt_peer_next;
            opt_set_reg    <= opt_set_next;
            choked_reg     <= choked_next;
            interested_reg <= interested_next;
            cmp_vld_reg    <= cmp_vld_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seeding_reg     <= seeding_next;
        ranked_reg      <= ranked_next;
        rank_left_reg   <= rank_left_next;
        slots_reg       <= slots_next;
        scan_addr_reg   <= scan_addr_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_rate_reg   <= best_rate_next;
        best_idx_reg    <= best_idx_next;
        best_found_reg  <= best_found_next;
        res_change_reg  <= res_change_next;
        res_peer_reg    <= res_peer_next;
        res_unchoke_reg <= res_unchoke_next;
        res_slots_reg   <= res_slots_next;
        res_opt_reg     <= res_opt_next;
        res_opt_vld_reg <= res_opt_vld_next;
        res_last_reg    <= res_last_next;
    end

    assign result_valid     = res_valid_reg;
    assign change_valid     = res_change_reg;
    assign peer_index_res   = res_peer_reg;
    assign unchoke          = res_unchoke_reg;
    assign slots_used       = res_slots_reg;
    assign optimistic_index = res_opt_reg;
    assign optimistic_valid = res_opt_vld_reg;
    assign last             = res_last_reg;

    // a picked peer must be a fresh winner of the scan
    a_pick_unranked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcs_pkg::ST_PICK) |-> (best_found_reg && !ranked_reg[best_idx_reg]))
        else $error("pick without a valid unranked winner");

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcs_pkg::ST_SCAN) |-> (rank_left_reg != '0))
        else $error("scan with no rank positions left");

    a_round_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == pcs_pkg::ACT_ROUND
                            || action == pcs_pkg::ACT_NEXT_OPT)) |=> busy)
        else $error("round transaction did not start");

    a_change_source: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && change_valid) |->
            ($past(state_reg) == pcs_pkg::ST_OPT || $past(state_reg) == pcs_pkg::ST_PICK))
        else $error("choke change from an unexpected state");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for peer_choke_scheduler. Drives update, round and
// optimistic-rotation commands, mirrors the peer table and choke flags in a
// scoreboard, and matches every choke change and round summary in order.
// ----------------------------------------------------------------------------

typedef struct {
    logic [1:0]  action;
    logic [4:0]  peer_index;
    logic [31:0] rate_down;
    logic [31:0] rate_up;
    logic        wants;
    logic        fresh;
    logic        seeding;
    logic        explicit_pick;
} choke_cmd_t;

typedef struct {
    logic       change_valid;
    logic [4:0] peer_index_res;
    logic       unchoke;
    logic [5:0] slots_used;
    logic [4:0] optimistic_index;
    logic       optimistic_valid;
    logic       last;
} choke_result_t;

class choke_tracker;
    bit [31:0] down_rates [32];
    bit [31:0] up_rates [32];
    bit        wants_flags [32];
    bit        choked [32];
    bit [4:0]  opt_peer;
    bit        opt_set;
    bit [5:0]  peer_count;
    bit [5:0]  unchoke_slots;
    choke_result_t choke_events_due [$];
    int        errors;

    function new();
        foreach (choked[i])
        begin
            choked[i]      = 1'b1;
            wants_flags[i] = 1'b0;
            down_rates[i]  = '0;
            up_rates[i]    = '0;
        end
        opt_peer      = '0;
        opt_set       = 1'b0;
        peer_count    = pcs_pkg::PEER_COUNT_RST;
        unchoke_slots = pcs_pkg::UNCHOKE_SLOTS_RST;
        errors        = 0;
    endfunction

    // 0 counts as 1, anything past the table is clamped
    function int live_peers();
        if (peer_count == 0)
            return 1;
        if (peer_count > 32)
            return 32;
        return int'(peer_count);
    endfunction

    function int pending();
        return choke_events_due.size();
    endfunction

    function void set_register(logic addr, bit [5:0] val);
        if (addr == pcs_pkg::CFG_PEER_COUNT)
            peer_count = val;
        else
            unchoke_slots = val;
    endfunction

    function void push_result(bit cv, bit [4:0] idx, bit un, bit [5:0] slots,
                              bit [4:0] oidx, bit ov, bit lst);
        choke_result_t r;
        r.change_valid     = cv;
        r.peer_index_res   = idx;
        r.unchoke          = un;
        r.slots_used       = slots;
        r.optimistic_index = oidx;
        r.optimistic_valid = ov;
        r.last             = lst;
        choke_events_due.push_back(r);
    endfunction

    function bit [31:0] rank_rate(int p, bit by_upload);
        return by_upload ? up_rates[p] : down_rates[p];
    endfunction

    function void run_round(bit by_upload);
        int order [32];
        bit taken [32];
        int n;
        int best;
        int p;
        int counted;
        bit opt_live;
        n = live_peers();
        foreach (taken[i])
            taken[i] = 1'b0;
        // fastest first; strict compare keeps the lower index on ties
        for (int rank = 0; rank < n; rank++)
        begin
            best = -1;
            for (int q = 0; q < n; q++)
                if (!taken[q] && (best < 0 || rank_rate(q, by_upload) > rank_rate(best, by_upload)))
                    best = q;
            order[rank] = best;
            taken[best] = 1'b1;
        end
        counted  = 0;
        opt_live = opt_set && (opt_peer < n);
        if (opt_live)
        begin
            if (choked[opt_peer])
            begin
                choked[opt_peer] = 1'b0;
                push_result(1'b1, opt_peer, 1'b1, '0, '0, 1'b0, 1'b0);
            end
            if (wants_flags[opt_peer])
                counted = 1;
        end
        for (int rank = 0; rank < n; rank++)
        begin
            p = order[rank];
            if (opt_live && p == opt_peer)
                continue;
            if (counted < unchoke_slots)
            begin
                if (wants_flags[p])
                    counted++;
                if (choked[p])
                begin
                    choked[p] = 1'b0;
                    push_result(1'b1, p[4:0], 1'b1, '0, '0, 1'b0, 1'b0);
                end
            end
            else if (!choked[p])
            begin
                choked[p] = 1'b1;
                push_result(1'b1, p[4:0], 1'b0, '0, '0, 1'b0, 1'b0);
            end
        end
        push_result(1'b0, '0, 1'b0, counted[5:0], opt_peer, opt_set, 1'b1);
    endfunction

    function void note_command(choke_cmd_t c);
        int nx;
        case (c.action)
            pcs_pkg::ACT_UPDATE:
            begin
                down_rates[c.peer_index]  = c.rate_down;
                up_rates[c.peer_index]    = c.rate_up;
                wants_flags[c.peer_index] = c.wants;
                if (c.fresh)
                    choked[c.peer_index] = 1'b1;
            end
            pcs_pkg::ACT_ROUND:
                run_round(c.seeding);
            pcs_pkg::ACT_NEXT_OPT:
            begin
                if (c.explicit_pick)
                    opt_peer = c.peer_index;
                else if (!opt_set)
                    opt_peer = '0;
                else
                begin
                    nx = opt_peer + 1;
                    opt_peer = (nx >= live_peers()) ? 5'd0 : nx[4:0];
                end
                opt_set = 1'b1;
                run_round(c.seeding);
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(choke_result_t got);
        choke_result_t want;
        if (choke_events_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, got change=%0b peer=%0d last=%0b",
                     $time, got.change_valid, got.peer_index_res, got.last);
            return;
        end
        want = choke_events_due.pop_front();
        compare_field("change_valid", 32'(want.change_valid), 32'(got.change_valid));
        compare_field("peer_index_res", 32'(want.peer_index_res), 32'(got.peer_index_res));
        compare_field("unchoke", 32'(want.unchoke), 32'(got.unchoke));
        compare_field("slots_used", 32'(want.slots_used), 32'(got.slots_used));
        compare_field("optimistic_index", 32'(want.optimistic_index),
                      32'(got.optimistic_index));
        compare_field("optimistic_valid", 32'(want.optimistic_valid),
                      32'(got.optimistic_valid));
        compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module tb;

    localparam int TABLE_DEPTH = 32;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  action = pcs_pkg::ACT_UPDATE;
    logic [4:0]  peer_index = '0;
    logic [31:0] rate_down = '0;
    logic [31:0] rate_up = '0;
    logic        wants = 1'b0;
    logic        fresh = 1'b0;
    logic        seeding = 1'b0;
    logic        explicit_pick = 1'b0;
    logic        cfg_wr = 1'b0;
    logic        cfg_addr = pcs_pkg::CFG_PEER_COUNT;
    logic [5:0]  cfg_data = '0;

    logic        busy;
    logic        result_valid;
    logic        change_valid;
    logic [4:0]  peer_index_res;
    logic        unchoke;
    logic [5:0]  slots_used;
    logic [4:0]  optimistic_index;
    logic        optimistic_valid;
    logic        last;

    choke_tracker tracker;
    bit           written [TABLE_DEPTH];

    peer_choke_scheduler #(.MAX_PEERS(TABLE_DEPTH)) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .peer_index      (peer_index),
        .rate_down       (rate_down),
        .rate_up         (rate_up),
        .wants           (wants),
        .fresh           (fresh),
        .seeding         (seeding),
        .explicit_pick   (explicit_pick),
        .cfg_wr          (cfg_wr),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .change_valid    (change_valid),
        .peer_index_res  (peer_index_res),
        .unchoke         (unchoke),
        .slots_used      (slots_used),
        .optimistic_index(optimistic_index),
        .optimistic_valid(optimistic_valid),
        .last            (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("FAIL peer_choke_scheduler");
        $finish;
    end

    always @(posedge clk)
    begin
        choke_result_t got;
        if (rst_n && result_valid)
        begin
            got.change_valid     = change_valid;
            got.peer_index_res   = peer_index_res;
            got.unchoke          = unchoke;
            got.slots_used       = slots_used;
            got.optimistic_index = optimistic_index;
            got.optimistic_valid = optimistic_valid;
            got.last             = last;
            tracker.check_result(got);
        end
    end

    function automatic choke_cmd_t compose(logic [1:0] act, logic [4:0] idx,
                                           logic [31:0] down, logic [31:0] up,
                                           logic w, logic f, logic s, logic p);
        choke_cmd_t c;
        c.action        = act;
        c.peer_index    = idx;
        c.rate_down     = down;
        c.rate_up       = up;
        c.wants         = w;
        c.fresh         = f;
        c.seeding       = s;
        c.explicit_pick = p;
        return c;
    endfunction

    // mostly extremes and tiny values so that equal rates are common
    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic int first_unwritten(int n);
        for (int i = 0; i < n; i++)
            if (!written[i])
                return i;
        return -1;
    endfunction

    function automatic choke_cmd_t random_cmd(int n);
        choke_cmd_t c;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            c.action = pcs_pkg::ACT_UPDATE;
        else if (pick < 14)
            c.action = pcs_pkg::ACT_ROUND;
        else if (pick < 19)
            c.action = pcs_pkg::ACT_NEXT_OPT;
        else
            c.action = ACT_UNUSED;
        if ($urandom_range(0, 3) != 0)
            c.peer_index = 5'($urandom_range(0, n - 1));
        else
            c.peer_index = 5'($urandom_range(0, 31));
        c.rate_down     = pick_rate();
        c.rate_up       = pick_rate();
        c.wants         = 1'($urandom_range(0, 1));
        c.fresh         = ($urandom_range(0, 2) == 0);
        c.seeding       = 1'($urandom_range(0, 1));
        c.explicit_pick = 1'($urandom_range(0, 1));
        // a round must never rank an entry whose rates were never loaded
        if ((c.action == pcs_pkg::ACT_ROUND || c.action == pcs_pkg::ACT_NEXT_OPT)
            && first_unwritten(n) >= 0)
        begin
            c.action     = pcs_pkg::ACT_UPDATE;
            c.peer_index = 5'(first_unwritten(n));
        end
        return c;
    endfunction

    // leaves start high; caller drops it when a gap follows
    task automatic send_command(input choke_cmd_t c);
        start         <= 1'b1;
        action        <= c.action;
        peer_index    <= c.peer_index;
        rate_down     <= c.rate_down;
        rate_up       <= c.rate_up;
        wants         <= c.wants;
        fresh         <= c.fresh;
        seeding       <= c.seeding;
        explicit_pick <= c.explicit_pick;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(c);
        if (c.action == pcs_pkg::ACT_UPDATE)
            written[c.peer_index] = 1'b1;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        // a trailing update or unused action may still be in flight
        repeat (8)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic configure(input logic [5:0] count, input logic [5:0] slots);
        cfg_wr   <= 1'b1;
        cfg_addr <= pcs_pkg::CFG_PEER_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_addr <= pcs_pkg::CFG_UNCHOKE_SLOTS;
        cfg_data <= slots;
        @(posedge clk);
        cfg_wr   <= 1'b0;
        tracker.set_register(pcs_pkg::CFG_PEER_COUNT, count);
        tracker.set_register(pcs_pkg::CFG_UNCHOKE_SLOTS, slots);
    endtask

    initial
    begin
        logic [5:0] phase_count [PHASES];
        logic [5:0] phase_slots [PHASES];
        choke_cmd_t c;
        bit idling;
        tracker = new();
        foreach (written[i])
            written[i] = 1'b0;
        phase_count = '{6'd63, 6'd2, 6'd32, 6'd0, 6'd8, 6'd5, 6'd12, 6'd32};
        phase_slots = '{6'd63, 6'd1, 6'd0, 6'd32, 6'd3, 6'd2, 6'd4, 6'd4};
        phase_count[5] = 6'($urandom_range(1, 12));
        phase_slots[5] = 6'($urandom_range(0, 6));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme rates, ties, every action, rotation corner cases
        configure(6'd4, 6'd2);
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd0, 32'hFFFF_FFFF, 32'h0,
                             1'b1, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd1, 32'h0, 32'hFFFF_FFFF,
                             1'b0, 1'b1, 1'b1, 1'b1));
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd2, 32'd1000, 32'd1000,
                             1'b1, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd3, 32'd1000, 32'd1000,
                             1'b1, 1'b1, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_ROUND, 5'd31, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_ROUND, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 1'b1, 1'b1, 1'b0));
        send_command(compose(ACT_UNUSED, 5'd5, 32'h1234_5678, 32'h8765_4321,
                             1'b1, 1'b1, 1'b0, 1'b1));
        // unset optimistic peer starts at 0, then advances round robin
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd17, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd17, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b1, 1'b0));
        // optimistic peer outside the peers in use, then wrap from it
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd31, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b1));
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd3, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd0, 32'd7, 32'd7,
                             1'b0, 1'b1, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_ROUND, 5'd0, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_UPDATE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 1'b1, 1'b1, 1'b1));
        wait_idle();
        // no slots: only the optimistic peer stays open
        configure(6'd4, 6'd0);
        send_command(compose(pcs_pkg::ACT_ROUND, 5'd0, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b1, 1'b0));
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd0, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        wait_idle();
        // zero peer count behaves as a single peer
        configure(6'd0, 6'd4);
        send_command(compose(pcs_pkg::ACT_ROUND, 5'd0, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b0));
        send_command(compose(pcs_pkg::ACT_NEXT_OPT, 5'd0, 32'h0, 32'h0,
                             1'b0, 1'b0, 1'b0, 1'b1));
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            configure(phase_count[ph], phase_slots[ph]);
            idling = (ph != 2) && (ph != PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                c = random_cmd(tracker.live_peers());
                send_command(c);
                if (ph == 4 && k == PHASE_ITEMS / 2)
                    wait_idle();
                else if (idling && $urandom_range(0, 5) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 11))
                        @(posedge clk);
                end
            end
            wait_idle();
        end

        repeat (64)
            @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS peer_choke_scheduler");
        else
            $display("FAIL peer_choke_scheduler");
        $finish;
    end

endmodule

// File: sim.f
src/pcs_pkg.sv
src/pcs_ram.sv
src/peer_choke_scheduler.sv
bench/tb.sv
